@@ design/sas_pkg.sv @@
package sas_pkg;

    // Script store geometry. The play position is an 8-bit value and the store
    // is addressed at the position modulo the depth, which with a depth of
    // 2**ADDR_W is the position itself.
    localparam int ADDR_W       = 8;
    localparam int SCRIPT_DEPTH = 2 ** ADDR_W;
    localparam int DATA_W       = 16;
    localparam int ENTRY_W      = 2 * DATA_W;

    // Number of script entries examined in one word before the walk gives up.
    localparam int MAX_WALK = 16;
    localparam int STEP_W   = (MAX_WALK > 2) ? $clog2(MAX_WALK) : 1;

    localparam logic [DATA_W-1:0] WHOLE_FRAME   = 16'h0100;
    localparam logic [DATA_W-1:0] FRACTION_MASK = 16'h00FF;
    localparam logic [DATA_W-1:0] CODE_LOOP     = 16'hFFFF;
    localparam logic [DATA_W-1:0] CODE_DELETE   = 16'h0001;
    localparam logic [DATA_W-1:0] CODE_HOLD     = 16'h0000;
    localparam logic [DATA_W-1:0] SPEED_RESET   = 16'h0100;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_STOP  = 2'd3
    } t_func;

    typedef struct packed {
        logic running;
        logic new_frame;
        logic deleted;
        logic walk_limit;
    } t_flags;

    typedef struct packed {
        logic   capture;     // latch the input word
        logic   mem_write;   // write the captured entry into the store
        logic   start_init;  // set up position, loop start and timers
        logic   rate_load;   // latch the step rate
        logic   rate_whole;  // rate is one whole frame instead of speed
        logic   step_clr;
        logic   step_inc;
        logic   cd_dec;      // count the frame countdown down
        logic   pos_inc;
        logic   pos_loop;    // jump back to the loop start
        logic   mem_read;
        logic   mul_load;
        logic   acc_short;   // keep the sum, no whole frame reached
        logic   frame_take;  // show the entry's frame and restart the countdown
        logic   clr_active;
        logic   out_load;
        t_flags out_flags;
    } t_dp_cmd;

    typedef struct packed {
        t_func func;
        logic  active;
        logic  speed_zero;
        logic  cd_zero;
        logic  cd_one;
        logic  dur_zero;
        logic  fr_loop;
        logic  fr_delete;
        logic  fr_hold;
        logic  sum_small;
        logic  step_last;
        logic  out_free;
    } t_dp_status;

endpackage

@@ design/sas_dp.sv @@
module sas_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sas_pkg::t_dp_cmd           i_cmd,
    output sas_pkg::t_dp_status        o_status,
    input  logic                       i_cfg_we,
    input  logic [15:0]                i_cfg_data,
    input  logic [1:0]                 i_func,
    input  logic [7:0]                 i_address,
    input  logic [15:0]                i_duration,
    input  logic [15:0]                i_frame_value,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic                       o_running,
    output logic [15:0]                o_frame_index,
    output logic                       o_new_frame,
    output logic                       o_deleted,
    output logic                       o_walk_limit
);
    import sas_pkg::*;

    logic [ENTRY_W-1:0] r_mem [SCRIPT_DEPTH];

    // Captured input word.
    t_func             r_func;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_dur;
    logic [DATA_W-1:0] r_fval;

    // Player state.
    logic [DATA_W-1:0] r_speed;
    logic [ADDR_W-1:0] r_pos;
    logic [ADDR_W-1:0] r_loop;
    logic [DATA_W-1:0] r_cd;
    logic [DATA_W-1:0] r_acc;
    logic              r_active;
    logic [DATA_W-1:0] r_shown;

    // Walk datapath.
    logic [DATA_W-1:0]  r_rate;
    logic [ENTRY_W-1:0] r_rdata;
    logic [DATA_W-1:0]  r_prod;
    logic [STEP_W-1:0]  r_step;

    // Output register.
    logic              r_out_valid;
    t_flags            r_out_flags;
    logic [DATA_W-1:0] r_out_frame;

    logic [DATA_W-1:0]  ent_dur;
    logic [DATA_W-1:0]  ent_fr;
    logic [DATA_W-1:0]  prod_full;
    logic [DATA_W-1:0]  sum;

    assign ent_dur   = r_rdata[ENTRY_W-1:DATA_W];
    assign ent_fr    = r_rdata[DATA_W-1:0];
    // Only the low half of the product reaches the wrapping accumulator.
    assign prod_full = ent_dur * r_rate;
    // The accumulator wraps modulo 2**16, as the timers do.
    assign sum       = r_acc + r_prod;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_write) begin
            r_mem[r_addr] <= {r_dur, r_fval};
        end
        if (i_cmd.mem_read) begin
            r_rdata <= r_mem[r_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= t_func'(i_func);
            r_addr <= i_address;
            r_dur  <= i_duration;
            r_fval <= i_frame_value;
        end
        if (i_cmd.rate_load) begin
            r_rate <= i_cmd.rate_whole ? WHOLE_FRAME : r_speed;
        end
        if (i_cmd.mul_load) begin
            r_prod <= prod_full;
        end
        if (i_cmd.step_clr) begin
            r_step <= '0;
        end else if (i_cmd.step_inc) begin
            r_step <= r_step + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_flags <= i_cmd.out_flags;
            r_out_frame <= r_shown;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed     <= SPEED_RESET;
            r_pos       <= '0;
            r_loop      <= '0;
            r_cd        <= '0;
            r_acc       <= '0;
            r_active    <= 1'b0;
            r_shown     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_speed <= i_cfg_data;
            end
            if (i_cmd.start_init) begin
                r_active <= 1'b1;
                r_pos    <= r_addr;
                r_loop   <= r_addr;
                r_cd     <= '0;
                r_acc    <= '0;
            end else begin
                if (i_cmd.clr_active) begin
                    r_active <= 1'b0;
                end
                if (i_cmd.pos_loop) begin
                    r_pos <= r_loop;
                end else if (i_cmd.pos_inc) begin
                    r_pos <= r_pos + 1'b1;
                end
                if (i_cmd.cd_dec) begin
                    r_cd <= r_cd - 1'b1;
                end else if (i_cmd.frame_take) begin
                    r_cd <= {8'h00, sum[DATA_W-1:8]};
                end
                if (i_cmd.acc_short) begin
                    r_acc <= sum;
                end else if (i_cmd.frame_take) begin
                    r_acc <= sum & FRACTION_MASK;
                end
                if (i_cmd.frame_take) begin
                    r_shown <= ent_fr;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.func       = r_func;
        o_status.active     = r_active;
        o_status.speed_zero = (r_speed == '0);
        o_status.cd_zero    = (r_cd == '0);
        o_status.cd_one     = (r_cd == DATA_W'(1));
        o_status.dur_zero   = (ent_dur == '0);
        o_status.fr_loop    = (ent_fr == CODE_LOOP);
        o_status.fr_delete  = (ent_fr == CODE_DELETE);
        o_status.fr_hold    = (ent_fr == CODE_HOLD);
        o_status.sum_small  = (sum < WHOLE_FRAME);
        o_status.step_last  = (r_step == STEP_W'(MAX_WALK - 1));
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_running     = r_out_flags.running;
    assign o_frame_index = r_out_frame;
    assign o_new_frame   = r_out_flags.new_frame;
    assign o_deleted     = r_out_flags.deleted;
    assign o_walk_limit  = r_out_flags.walk_limit;

endmodule

@@ design/sas_ctrl.sv @@
module sas_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sas_pkg::t_dp_status i_status,
    output sas_pkg::t_dp_cmd    o_cmd
);
    import sas_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_READ,
        ST_MUL,
        ST_EVAL,
        ST_FIN
    } t_state;

    t_state r_state, n_state;
    t_flags r_flags, n_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_flags <= '0;
        end else begin
            r_state <= n_state;
            r_flags <= n_flags;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_flags   = r_flags;
        o_cmd     = '0;
        o_cmd.out_flags = r_flags;
        o_in_ready = (r_state == ST_IDLE);

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_CMD;
                end
            end
            ST_CMD: begin
                n_flags = '0;
                n_state = ST_FIN;
                unique case (i_status.func)
                    FUNC_LOAD: begin
                        o_cmd.mem_write = 1'b1;
                        n_flags.running = i_status.active;
                    end
                    FUNC_START: begin
                        o_cmd.start_init = 1'b1;
                        o_cmd.rate_load  = 1'b1;
                        o_cmd.rate_whole = 1'b1;
                        o_cmd.step_clr   = 1'b1;
                        n_state          = ST_READ;
                    end
                    FUNC_TICK: begin
                        o_cmd.rate_load = 1'b1;
                        o_cmd.step_clr  = 1'b1;
                        n_flags.running = i_status.active;
                        if (i_status.active && !i_status.speed_zero) begin
                            if (i_status.cd_zero) begin
                                n_state = ST_READ;
                            end else begin
                                o_cmd.cd_dec = 1'b1;
                                // The countdown expiring moves on to the next entry.
                                if (i_status.cd_one) begin
                                    o_cmd.pos_inc = 1'b1;
                                    n_state       = ST_READ;
                                end
                            end
                        end
                    end
                    FUNC_STOP: begin
                        o_cmd.clr_active = 1'b1;
                        n_flags.deleted  = i_status.active;
                    end
                    default: begin
                    end
                endcase
            end
            ST_READ: begin
                o_cmd.mem_read = 1'b1;
                n_state        = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul_load = 1'b1;
                n_state        = ST_EVAL;
            end
            ST_EVAL: begin
                n_flags         = '0;
                n_flags.running = 1'b1;
                n_state         = ST_FIN;
                if (i_status.dur_zero && i_status.fr_delete) begin
                    o_cmd.clr_active = 1'b1;
                    n_flags.running  = 1'b0;
                    n_flags.deleted  = 1'b1;
                end else if (i_status.dur_zero && i_status.fr_hold) begin
                    n_flags.running = 1'b0;
                end else if (!(i_status.dur_zero && i_status.fr_loop)
                             && !i_status.sum_small) begin
                    o_cmd.frame_take  = 1'b1;
                    n_flags.new_frame = 1'b1;
                end else begin
                    // A loop code or a step short of a whole frame keeps walking.
                    if (i_status.dur_zero && i_status.fr_loop) begin
                        o_cmd.pos_loop = 1'b1;
                    end else begin
                        o_cmd.acc_short = 1'b1;
                        o_cmd.pos_inc   = 1'b1;
                    end
                    if (i_status.step_last) begin
                        n_flags.walk_limit = 1'b1;
                    end else begin
                        o_cmd.step_inc = 1'b1;
                        n_state        = ST_READ;
                    end
                end
            end
            ST_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/sprite_animation_sequencer_top.sv @@
// Sprite animation script player.
// Input channel (i_in_valid / o_in_ready) carries one command word: load a
// script entry, start at an address, tick once per video frame, or stop.
// Output channel (o_out_valid / i_out_ready) returns exactly one result word
// per command: running, shown frame index and the new_frame, deleted and
// walk_limit flags. The speed register (8.8 fixed point) is written through
// i_cfg_we / i_cfg_data; the user must write it only while the block is
// idle, which the block itself does not enforce. For a load, a stop, an
// inactive or frozen tick and a tick that only counts down, the word passes
// through ST_CMD and then ST_FIN. Each script entry examined by a start or an
// expiring tick adds the states ST_READ, ST_MUL and ST_EVAL (store read,
// multiply, accumulate), with at most MAX_WALK entries per word. The
// single-port script store read and the registered duration times speed
// product are why each entry needs these separate states.
// One command word is processed at a time; the next is accepted once the
// result has gone into the output register, even while that result still
// waits. A stalled receiver holds the result and blocks only the completion
// of the following command.
// Reset clears the player state, sets speed to 0x100 and empties the output
// register; the script store is not cleared and must be loaded before use.
module sprite_animation_sequencer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_address,
    input  logic [15:0] i_duration,
    input  logic [15:0] i_frame_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_running,
    output logic [15:0] o_frame_index,
    output logic        o_new_frame,
    output logic        o_deleted,
    output logic        o_walk_limit
);
    import sas_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    sas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sas_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_func        (i_func),
        .i_address     (i_address),
        .i_duration    (i_duration),
        .i_frame_value (i_frame_value),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_running     (o_running),
        .o_frame_index (o_frame_index),
        .o_new_frame   (o_new_frame),
        .o_deleted     (o_deleted),
        .o_walk_limit  (o_walk_limit)
    );

endmodule

@@ design/sas_checker.sv @@
module sas_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_running,
    input logic [15:0] o_frame_index,
    input logic        o_new_frame,
    input logic        o_deleted,
    input logic        o_walk_limit
);

    // A waiting result word holds its frame index until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_frame_index))
        else $error("result word changed while stalled");

    // Only one command word is in flight at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second word accepted while busy");

    a_new_frame_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_new_frame |-> o_running && !o_deleted && !o_walk_limit)
        else $error("new frame reported on a stopped animation");

    a_deleted_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_deleted |-> !o_running && !o_walk_limit)
        else $error("deleted animation still running");

endmodule

bind sprite_animation_sequencer_top sas_port_checker u_sas_checker (.*);
